// ===== sv/vfcm_pkg.sv =====
// ----------------------------------------------------------------------------
// vfcm_pkg: shared types and constants of the voxel face culling mesher
// Holds field widths, action and command codes, face directions and the
// command record that travels from the front to the back.
// ----------------------------------------------------------------------------
package vfcm_pkg;

	localparam int CHUNK_EDGE_DEF    = 16;
	localparam int ATLAS_COLUMNS_DEF = 2;

	localparam int COORD_W = 4;
	localparam int KIND_W  = 3;
	localparam int ACT_W   = 2;
	localparam int DIR_W   = 3;
	localparam int VERT_W  = 17;
	localparam int COL_W   = 1;
	localparam int ROW_W   = 2;

	localparam int FACES  = 6;
	localparam int QDEPTH = 2;

	typedef logic [ACT_W-1:0] action_t;
	localparam action_t ACT_WRITE = 2'd0;
	localparam action_t ACT_EMIT  = 2'd1;
	localparam action_t ACT_CLEAR = 2'd2;

	typedef logic [1:0] op_t;
	localparam op_t OP_WRITE = 2'd0;
	localparam op_t OP_EMIT  = 2'd1;
	localparam op_t OP_CLEAR = 2'd2;

	typedef logic [DIR_W-1:0] dir_t;
	localparam dir_t DIR_NX = 3'd0;
	localparam dir_t DIR_PX = 3'd1;
	localparam dir_t DIR_NY = 3'd2;
	localparam dir_t DIR_PY = 3'd3;
	localparam dir_t DIR_NZ = 3'd4;
	localparam dir_t DIR_PZ = 3'd5;

	typedef struct packed {
		op_t                op;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [KIND_W-1:0]  kind;
	} cmd_t;

endpackage

// ===== sv/voxel_face_culling_mesher.sv =====
// ----------------------------------------------------------------------------
// voxel_face_culling_mesher: face culling mesher for one voxel chunk
// A queued command waits in the front queue until the back pops it while idle;
// write and clear are done at the pop. An emit pops, reads the cell and its
// six neighbours in turn, waits for the last read data and then sends a
// record for each exposed face, holding while out_stall is high. The back
// takes no new command until idle again; the front queues two items.
// Reset clears the queue, the sequencer and the vertex counter; the block store
// is undefined until written and gets no clearing pass.
// ----------------------------------------------------------------------------
module voxel_face_culling_mesher #(
	parameter int CHUNK_EDGE    = vfcm_pkg::CHUNK_EDGE_DEF,
	parameter int ATLAS_COLUMNS = vfcm_pkg::ATLAS_COLUMNS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [vfcm_pkg::ACT_W-1:0]   action,
	input  logic [vfcm_pkg::COORD_W-1:0] cell_x,
	input  logic [vfcm_pkg::COORD_W-1:0] cell_y,
	input  logic [vfcm_pkg::COORD_W-1:0] cell_z,
	input  logic [vfcm_pkg::KIND_W-1:0]  block_kind,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [vfcm_pkg::DIR_W-1:0]   face_dir,
	output logic [vfcm_pkg::COORD_W-1:0] out_x,
	output logic [vfcm_pkg::COORD_W-1:0] out_y,
	output logic [vfcm_pkg::COORD_W-1:0] out_z,
	output logic [vfcm_pkg::COL_W-1:0]   tile_col,
	output logic [vfcm_pkg::ROW_W-1:0]   tile_row,
	output logic [vfcm_pkg::VERT_W-1:0]  first_vertex,
	output logic                         last_face
);

	localparam int CELLS = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
	localparam int AW    = $clog2(CELLS);

	logic                        q_valid;
	vfcm_pkg::cmd_t              q_cmd;
	logic                        q_pop;
	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [vfcm_pkg::KIND_W-1:0] ram_wdata;
	logic                        ram_re;
	logic [AW-1:0]               ram_raddr;
	logic [vfcm_pkg::KIND_W-1:0] ram_rdata;

	vfcm_front #(
		.CHUNK_EDGE(CHUNK_EDGE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.cell_x    (cell_x),
		.cell_y    (cell_y),
		.cell_z    (cell_z),
		.block_kind(block_kind),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop)
	);

	vfcm_ram #(
		.WIDTH(vfcm_pkg::KIND_W),
		.DEPTH(CELLS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	vfcm_back #(
		.CHUNK_EDGE   (CHUNK_EDGE),
		.ATLAS_COLUMNS(ATLAS_COLUMNS),
		.AW           (AW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_cmd       (q_cmd),
		.q_pop       (q_pop),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.face_dir    (face_dir),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_z       (out_z),
		.tile_col    (tile_col),
		.tile_row    (tile_row),
		.first_vertex(first_vertex),
		.last_face   (last_face)
	);

endmodule

// ===== sv/vfcm_ram.sv =====
// ----------------------------------------------------------------------------
// vfcm_ram: generic single-write, single-read memory
// One write port and one read port with registered read data. The contents
// are not reset.
// ----------------------------------------------------------------------------
module vfcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/vfcm_front.sv =====
// ----------------------------------------------------------------------------
// vfcm_front: input classification and command queue
// Accepts input items, drops those that have no effect and queues the rest
// as commands for the back.
// ----------------------------------------------------------------------------
module vfcm_front #(
	parameter int CHUNK_EDGE = vfcm_pkg::CHUNK_EDGE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  vfcm_pkg::action_t                action,
	input  logic [vfcm_pkg::COORD_W-1:0]     cell_x,
	input  logic [vfcm_pkg::COORD_W-1:0]     cell_y,
	input  logic [vfcm_pkg::COORD_W-1:0]     cell_z,
	input  logic [vfcm_pkg::KIND_W-1:0]      block_kind,
	output logic                             q_valid,
	output vfcm_pkg::cmd_t                   q_cmd,
	input  logic                             q_pop
);

	localparam int QAW = (vfcm_pkg::QDEPTH > 1) ? $clog2(vfcm_pkg::QDEPTH) : 1;
	localparam int CW  = $clog2(vfcm_pkg::QDEPTH + 1);

	vfcm_pkg::cmd_t  fifo_q [vfcm_pkg::QDEPTH];
	logic [QAW-1:0]  wr_ptr_q;
	logic [QAW-1:0]  rd_ptr_q;
	logic [CW-1:0]   count_q;
	vfcm_pkg::cmd_t  in_cmd;
	logic            in_range;
	logic            keep;
	logic            push;

	assign in_range = (int'(cell_x) < CHUNK_EDGE) && (int'(cell_y) < CHUNK_EDGE) &&
		(int'(cell_z) < CHUNK_EDGE);

	always_comb begin
		in_cmd      = '0;
		in_cmd.x    = cell_x;
		in_cmd.y    = cell_y;
		in_cmd.z    = cell_z;
		in_cmd.kind = block_kind;
		keep        = 1'b0;
		case (action)
			vfcm_pkg::ACT_WRITE: begin
				in_cmd.op = vfcm_pkg::OP_WRITE;
				keep      = in_range;
			end
			vfcm_pkg::ACT_EMIT: begin
				in_cmd.op = vfcm_pkg::OP_EMIT;
				keep      = in_range;
			end
			vfcm_pkg::ACT_CLEAR: begin
				in_cmd.op = vfcm_pkg::OP_CLEAR;
				keep      = 1'b1;
			end
			default: begin
				in_cmd.op = vfcm_pkg::OP_CLEAR;
				keep      = 1'b0;
			end
		endcase
	end

	// Items that do nothing are accepted but never queued.
	assign in_stall = (count_q == CW'(vfcm_pkg::QDEPTH));
	assign push     = in_valid && !in_stall && keep;
	assign q_valid  = (count_q != '0);
	assign q_cmd    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == vfcm_pkg::QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == vfcm_pkg::QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= vfcm_pkg::QDEPTH)
		else $error("command queue count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> count_q != '0)
		else $error("command popped from empty queue");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !q_pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not grow on push");

endmodule

// ===== sv/vfcm_back.sv =====
// ----------------------------------------------------------------------------
// vfcm_back: command execution and face record sequencer
// Writes block types, clears the vertex counter and, for an emit, reads the
// cell and its six neighbours one per cycle before sending a record for each
// exposed face of a non-empty cell through the output register.
// ----------------------------------------------------------------------------
module vfcm_back #(
	parameter int CHUNK_EDGE    = vfcm_pkg::CHUNK_EDGE_DEF,
	parameter int ATLAS_COLUMNS = vfcm_pkg::ATLAS_COLUMNS_DEF,
	parameter int AW            = $clog2(CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  vfcm_pkg::cmd_t               q_cmd,
	output logic                         q_pop,
	output logic                         ram_we,
	output logic [AW-1:0]                ram_waddr,
	output logic [vfcm_pkg::KIND_W-1:0]  ram_wdata,
	output logic                         ram_re,
	output logic [AW-1:0]                ram_raddr,
	input  logic [vfcm_pkg::KIND_W-1:0]  ram_rdata,
	output logic                         out_valid,
	input  logic                         out_stall,
	output vfcm_pkg::dir_t               face_dir,
	output logic [vfcm_pkg::COORD_W-1:0] out_x,
	output logic [vfcm_pkg::COORD_W-1:0] out_y,
	output logic [vfcm_pkg::COORD_W-1:0] out_z,
	output logic [vfcm_pkg::COL_W-1:0]   tile_col,
	output logic [vfcm_pkg::ROW_W-1:0]   tile_row,
	output logic [vfcm_pkg::VERT_W-1:0]  first_vertex,
	output logic                         last_face
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_READ  = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_FACES = 2'd3;

	localparam logic [2:0] LAST_READ = 3'(vfcm_pkg::FACES);

	logic [1:0]                   state_q;
	logic [2:0]                   rd_idx_q;
	logic [vfcm_pkg::COORD_W-1:0] x_q;
	logic [vfcm_pkg::COORD_W-1:0] y_q;
	logic [vfcm_pkg::COORD_W-1:0] z_q;
	logic [vfcm_pkg::KIND_W-1:0]  type_q;
	logic [vfcm_pkg::FACES-1:0]   mask_q;
	logic [vfcm_pkg::VERT_W-1:0]  vcount_q;
	logic                         chk_vld_s1;
	logic [2:0]                   chk_idx_s1;
	logic                         chk_out_s1;
	logic                         out_valid_q;
	vfcm_pkg::dir_t               dir_q;
	logic [vfcm_pkg::COORD_W-1:0] ox_q;
	logic [vfcm_pkg::COORD_W-1:0] oy_q;
	logic [vfcm_pkg::COORD_W-1:0] oz_q;
	logic [vfcm_pkg::COL_W-1:0]   col_q;
	logic [vfcm_pkg::ROW_W-1:0]   row_q;
	logic [vfcm_pkg::COL_W-1:0]   ocol_q;
	logic [vfcm_pkg::ROW_W-1:0]   orow_q;
	logic [vfcm_pkg::VERT_W-1:0]  fv_q;
	logic                         last_q;

	logic [vfcm_pkg::COORD_W-1:0] nx;
	logic [vfcm_pkg::COORD_W-1:0] ny;
	logic [vfcm_pkg::COORD_W-1:0] nz;
	logic                         n_out;
	vfcm_pkg::dir_t               rd_dir;
	vfcm_pkg::dir_t               pick;
	logic [vfcm_pkg::FACES-1:0]   pick_bit;
	logic                         slot_free;
	logic                         out_load;
	int                           row_n;
	logic [vfcm_pkg::COL_W-1:0]   col_d;
	logic [vfcm_pkg::ROW_W-1:0]   row_d;

	function automatic logic [AW-1:0] cell_addr(input logic [vfcm_pkg::COORD_W-1:0] cx,
		input logic [vfcm_pkg::COORD_W-1:0] cy, input logic [vfcm_pkg::COORD_W-1:0] cz);
		cell_addr = AW'((int'(cx) * CHUNK_EDGE + int'(cy)) * CHUNK_EDGE + int'(cz));
	endfunction

	// The atlas row is the number of whole atlas rows that fit at or below the kind.
	function automatic int tile_rows(input logic [vfcm_pkg::KIND_W-1:0] k);
		int n;
		n = 0;
		for (int i = 1; i < (1 << vfcm_pkg::KIND_W); i++) begin
			if (int'(k) >= i * ATLAS_COLUMNS) begin
				n = n + 1;
			end
		end
		return n;
	endfunction

	// Read slot zero is the cell itself; slot d+1 is the neighbour in direction d.
	assign rd_dir = vfcm_pkg::dir_t'(rd_idx_q - 3'd1);

	always_comb begin
		nx    = x_q;
		ny    = y_q;
		nz    = z_q;
		n_out = 1'b0;
		if (rd_idx_q != '0) begin
			case (rd_dir)
				vfcm_pkg::DIR_NX: begin
					nx    = x_q - 1'b1;
					n_out = (x_q == '0);
				end
				vfcm_pkg::DIR_PX: begin
					nx    = x_q + 1'b1;
					n_out = (int'(x_q) + 1 >= CHUNK_EDGE);
				end
				vfcm_pkg::DIR_NY: begin
					ny    = y_q - 1'b1;
					n_out = (y_q == '0);
				end
				vfcm_pkg::DIR_PY: begin
					ny    = y_q + 1'b1;
					n_out = (int'(y_q) + 1 >= CHUNK_EDGE);
				end
				vfcm_pkg::DIR_NZ: begin
					nz    = z_q - 1'b1;
					n_out = (z_q == '0);
				end
				vfcm_pkg::DIR_PZ: begin
					nz    = z_q + 1'b1;
					n_out = (int'(z_q) + 1 >= CHUNK_EDGE);
				end
				default: begin
					n_out = 1'b1;
				end
			endcase
		end
		// An outside neighbour is never looked at, so read the cell itself.
		if (n_out) begin
			nx = x_q;
			ny = y_q;
			nz = z_q;
		end
	end

	assign ram_re    = (state_q == ST_READ);
	assign ram_raddr = cell_addr(nx, ny, nz);

	assign q_pop     = q_valid && (state_q == ST_IDLE);
	assign ram_we    = q_pop && (q_cmd.op == vfcm_pkg::OP_WRITE);
	assign ram_waddr = cell_addr(q_cmd.x, q_cmd.y, q_cmd.z);
	assign ram_wdata = q_cmd.kind;

	// Lowest exposed face still to send.
	always_comb begin
		pick = vfcm_pkg::DIR_NX;
		for (int i = vfcm_pkg::FACES - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				pick = vfcm_pkg::dir_t'(i);
			end
		end
		pick_bit = vfcm_pkg::FACES'(1) << pick;
	end

	assign row_n = tile_rows(ram_rdata);
	assign col_d = vfcm_pkg::COL_W'(int'(ram_rdata) - row_n * ATLAS_COLUMNS);
	assign row_d = vfcm_pkg::ROW_W'(row_n);

	assign slot_free = !out_valid_q || !out_stall;
	assign out_load  = (state_q == ST_FACES) && (type_q != '0) && (mask_q != '0) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_idx_q    <= '0;
			vcount_q    <= '0;
			chk_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			chk_vld_s1 <= (state_q == ST_READ);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					rd_idx_q <= '0;
					if (q_pop && q_cmd.op == vfcm_pkg::OP_CLEAR) begin
						vcount_q <= '0;
					end
					if (q_pop && q_cmd.op == vfcm_pkg::OP_EMIT) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (rd_idx_q == LAST_READ) begin
						state_q <= ST_WAIT;
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				ST_WAIT: begin
					state_q <= ST_FACES;
				end
				ST_FACES: begin
					if (type_q == '0 || mask_q == '0) begin
						state_q <= ST_IDLE;
					end else if (out_load) begin
						vcount_q <= vcount_q + vfcm_pkg::VERT_W'(4);
						if ((mask_q & ~pick_bit) == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= rd_idx_q;
		chk_out_s1 <= n_out;
		if (q_pop) begin
			x_q <= q_cmd.x;
			y_q <= q_cmd.y;
			z_q <= q_cmd.z;
		end
		if (chk_vld_s1) begin
			if (chk_idx_s1 == '0) begin
				type_q <= ram_rdata;
				col_q  <= col_d;
				row_q  <= row_d;
			end else begin
				mask_q[chk_idx_s1 - 3'd1] <= chk_out_s1 || (ram_rdata == '0);
			end
		end
		if (out_load) begin
			mask_q <= mask_q & ~pick_bit;
			dir_q  <= pick;
			ox_q   <= x_q;
			oy_q   <= y_q;
			oz_q   <= z_q;
			ocol_q <= col_q;
			orow_q <= row_q;
			fv_q   <= vcount_q;
			last_q <= ((mask_q & ~pick_bit) == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign face_dir     = dir_q;
	assign out_x        = ox_q;
	assign out_y        = oy_q;
	assign out_z        = oz_q;
	assign tile_col     = ocol_q;
	assign tile_row     = orow_q;
	assign first_vertex = fv_q;
	assign last_face    = last_q;

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> vcount_q == $past(vcount_q) + vfcm_pkg::VERT_W'(4))
		else $error("vertex counter did not advance by four on a face");

	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> rd_idx_q <= LAST_READ)
		else $error("neighbour read index out of range");

	a_load_faces: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> state_q == ST_FACES && !q_pop)
		else $error("face record loaded outside the face phase");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !out_load)
		else $error("waiting face record overwritten");

endmodule
